// File: rtl/f40_pkg.sv
// Shared types and constants for the format40 rectangle delta decoder.
package f40_pkg;

    localparam int COL_W      = 12;   // column counter and width registers
    localparam int WEFF_W     = 13;   // effective width, up to 4096
    localparam int RUN_W      = 15;   // run length counter
    localparam int TOTAL_W    = 16;   // column plus skip length
    localparam int OUT_ADDR_W = 20;   // address field of a result

    localparam logic [WEFF_W-1:0] FULL_WIDTH_COLS = 13'd4096;

    // Request kinds
    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;
    localparam logic [1:0] REQ_INVALID = 2'd3;

    // What the decoder expects next
    localparam logic [1:0] WANT_BYTE    = 2'd0;
    localparam logic [1:0] WANT_ADVANCE = 2'd1;
    localparam logic [1:0] WANT_DONE    = 2'd2;

    // Configuration register indices
    localparam logic [1:0] CFG_RECT_WIDTH = 2'd0;
    localparam logic [1:0] CFG_ROW_PITCH  = 2'd1;
    localparam logic [1:0] CFG_WRITE_MODE = 2'd2;

    // Command codes
    localparam logic [7:0]  CMD_FILL     = 8'h00;
    localparam logic [7:0]  CMD_LONG     = 8'h80;
    localparam logic [15:0] LONG_END     = 16'h0000;
    localparam int          LONG_RUN_BIT = 15;
    localparam int          LONG_FILL_BIT = 14;

    typedef struct packed {
        logic                  write_valid;
        logic [OUT_ADDR_W-1:0] write_address;
        logic [7:0]            write_data;
        logic                  write_is_xor;
        logic [1:0]            next_wanted;
        logic                  kind_error;
    } t_result;

endpackage

// File: rtl/f40_div.sv
// Radix-2 restoring divider that splits a skip into whole rows and a column.
module f40_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [f40_pkg::TOTAL_W-1:0]  i_dividend,
    input  logic [f40_pkg::WEFF_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [f40_pkg::TOTAL_W-1:0]  o_quotient,
    output logic [f40_pkg::COL_W-1:0]    o_remainder
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [3:0]                    r_cnt, n_cnt;
    logic [f40_pkg::TOTAL_W-1:0]   r_work, n_work;
    logic [f40_pkg::WEFF_W-1:0]    r_rem, n_rem;
    logic [f40_pkg::WEFF_W-1:0]    r_div, n_div;
    logic [f40_pkg::WEFF_W:0]      shifted;
    logic [f40_pkg::WEFF_W:0]      diff;
    logic                          fits;

    // one quotient bit a cycle
    assign shifted = {r_rem, r_work[f40_pkg::TOTAL_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd15;
            n_work = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = fits ? diff[f40_pkg::WEFF_W-1:0] : shifted[f40_pkg::WEFF_W-1:0];
            n_work = {r_work[f40_pkg::TOTAL_W-2:0], fits};
            n_cnt  = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_work <= '0;
            r_rem  <= '0;
            r_div  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_work <= n_work;
            r_rem  <= n_rem;
            r_div  <= n_div;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    // remainder is below the divisor, so at most 4095
    assign o_remainder = r_rem[f40_pkg::COL_W-1:0];

endmodule

// File: rtl/format40_rect_delta_decoder.sv
// Format40 delta decoder: turns a stream of encoded bytes into pixel writes in a rectangle.
//
// Each request carries an encoded byte, an advance (one pixel of a pending fill) or a
// restart, and yields exactly one result: an optional pixel write with its byte address,
// the kind of request expected next and a wrong-kind flag. One request is in flight at a
// time: a byte or advance request is decoded on acceptance, then its result is handed to
// the output register once that is free. A skip command first goes through the shared
// restoring divider, which splits column plus skip length into whole rows and a new
// column, then through a row multiply step and an address add step.
// The output register lets the next request be taken while a result still waits there.
// Configuration writes are always ready and must only be issued while the block is idle.
// Addresses wrap at ADDR_BITS bits; the result shows the low 20 bits.
module format40_rect_delta_decoder #(
    parameter int ADDR_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_src_byte,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_write_valid,
    output logic [19:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic        o_write_is_xor,
    output logic [1:0]  o_next_wanted,
    output logic        o_kind_error
);

    localparam int AW_EXT = (ADDR_BITS > f40_pkg::OUT_ADDR_W) ? ADDR_BITS
                                                              : f40_pkg::OUT_ADDR_W;
    localparam int PROD_W = f40_pkg::TOTAL_W + ADDR_BITS;

    typedef enum logic [2:0] {
        PH_CMD, PH_FILL_COUNT, PH_FILL_VALUE, PH_LITERAL,
        PH_LONG_LO, PH_LONG_HI, PH_FILL_RUN, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_MUL, ST_ADD, ST_DONE
    } t_seq;

    t_seq                          r_seq, n_seq;
    t_phase                        r_phase, n_phase;
    logic [f40_pkg::RUN_W-1:0]     r_run_left, n_run_left;
    logic [7:0]                    r_fill_value, n_fill_value;
    logic [7:0]                    r_long_low, n_long_low;
    logic [f40_pkg::COL_W-1:0]     r_column, n_column;
    logic [ADDR_BITS-1:0]          r_dest, n_dest;
    logic [f40_pkg::RUN_W-1:0]     r_skip_n, n_skip_n;
    logic [ADDR_BITS-1:0]          r_prod, n_prod;
    logic [f40_pkg::COL_W-1:0]     r_rect_width, n_rect_width;
    logic [f40_pkg::COL_W-1:0]     r_row_pitch, n_row_pitch;
    logic                          r_write_mode, n_write_mode;
    f40_pkg::t_result              r_res, n_res;
    f40_pkg::t_result              r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    logic                          in_acc;
    logic                          out_free;
    logic [1:0]                    want;
    logic [f40_pkg::WEFF_W-1:0]    w_eff;
    logic [ADDR_BITS-1:0]          step;
    logic                          pix_wrap;
    logic [f40_pkg::COL_W-1:0]     pix_column;
    logic [ADDR_BITS-1:0]          pix_dest;
    logic [AW_EXT-1:0]             dest_ext;
    logic [15:0]                   long_val;
    logic                          skip_go;
    logic [f40_pkg::RUN_W-1:0]     skip_len;
    logic [f40_pkg::RUN_W-1:0]     run_dec;
    logic                          div_done;
    logic [f40_pkg::TOTAL_W-1:0]   div_quot;
    logic [f40_pkg::COL_W-1:0]     div_rem;
    logic [f40_pkg::TOTAL_W-1:0]   skip_total;
    logic [PROD_W-1:0]             prod_full;

    // width zero stands for 4096 columns
    assign w_eff = (r_rect_width == '0) ? f40_pkg::FULL_WIDTH_COLS
                                        : {1'b0, r_rect_width};
    // gap from the end of one rectangle row to the start of the next, wrapping
    assign step  = ADDR_BITS'(r_row_pitch) - ADDR_BITS'(w_eff);

    // address and column after one pixel
    assign pix_wrap   = ({1'b0, r_column} + 13'd1) >= w_eff;
    assign pix_column = pix_wrap ? '0 : r_column + 12'd1;
    assign pix_dest   = r_dest + ADDR_BITS'(1) + (pix_wrap ? step : '0);
    assign dest_ext   = AW_EXT'(r_dest);

    assign long_val = {i_src_byte, r_long_low};
    assign run_dec  = r_run_left - 15'd1;

    assign want = (r_phase == PH_DONE)     ? f40_pkg::WANT_DONE :
                  (r_phase == PH_FILL_RUN) ? f40_pkg::WANT_ADVANCE : f40_pkg::WANT_BYTE;

    assign o_in_stall  = (r_seq != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && (r_seq == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign skip_total = f40_pkg::TOTAL_W'(r_column) + f40_pkg::TOTAL_W'(skip_len);

    f40_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc && skip_go),
        .i_dividend  (skip_total),
        .i_divisor   (w_eff),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // whole rows crossed times row step; only the low address bits matter
    assign prod_full = {{ADDR_BITS{1'b0}}, div_quot} * {{f40_pkg::TOTAL_W{1'b0}}, step};

    always_comb begin
        n_seq        = r_seq;
        n_phase      = r_phase;
        n_run_left   = r_run_left;
        n_fill_value = r_fill_value;
        n_long_low   = r_long_low;
        n_column     = r_column;
        n_dest       = r_dest;
        n_skip_n     = r_skip_n;
        n_prod       = r_prod;
        n_rect_width = r_rect_width;
        n_row_pitch  = r_row_pitch;
        n_write_mode = r_write_mode;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        skip_go      = 1'b0;
        skip_len     = '0;

        // configuration, taken whenever offered
        if (i_cfg_valid) begin
            case (i_cfg_index)
                f40_pkg::CFG_RECT_WIDTH: n_rect_width = i_cfg_data;
                f40_pkg::CFG_ROW_PITCH:  n_row_pitch  = i_cfg_data;
                f40_pkg::CFG_WRITE_MODE: n_write_mode = i_cfg_data[0];
                default: ;
            endcase
        end

        // drop a result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_seq)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    if (i_req_type == f40_pkg::REQ_RESTART) begin
                        n_phase      = PH_CMD;
                        n_run_left   = '0;
                        n_fill_value = '0;
                        n_long_low   = '0;
                        n_column     = '0;
                        n_dest       = '0;
                    end else if (i_req_type == f40_pkg::REQ_INVALID || i_req_type != want) begin
                        n_res.kind_error = 1'b1;
                    end else if (i_req_type == f40_pkg::REQ_ADVANCE) begin
                        n_res.write_valid   = 1'b1;
                        n_res.write_address = dest_ext[f40_pkg::OUT_ADDR_W-1:0];
                        n_res.write_data    = r_fill_value;
                        n_res.write_is_xor  = !r_write_mode;
                        n_column            = pix_column;
                        n_dest              = pix_dest;
                        n_run_left          = run_dec;
                        if (run_dec == '0) begin
                            n_phase = PH_CMD;
                        end
                    end else begin
                        case (r_phase)
                            PH_CMD: begin
                                if (i_src_byte == f40_pkg::CMD_FILL) begin
                                    n_phase = PH_FILL_COUNT;
                                end else if (!i_src_byte[7]) begin
                                    n_run_left = f40_pkg::RUN_W'(i_src_byte);
                                    n_phase    = PH_LITERAL;
                                end else if (i_src_byte != f40_pkg::CMD_LONG) begin
                                    skip_go  = 1'b1;
                                    skip_len = f40_pkg::RUN_W'(i_src_byte[6:0]);
                                end else begin
                                    n_phase = PH_LONG_LO;
                                end
                            end
                            PH_FILL_COUNT: begin
                                n_run_left = f40_pkg::RUN_W'(i_src_byte);
                                n_phase    = PH_FILL_VALUE;
                            end
                            PH_FILL_VALUE: begin
                                n_fill_value = i_src_byte;
                                n_phase      = (r_run_left == '0) ? PH_CMD : PH_FILL_RUN;
                            end
                            PH_LITERAL: begin
                                n_res.write_valid   = 1'b1;
                                n_res.write_address = dest_ext[f40_pkg::OUT_ADDR_W-1:0];
                                n_res.write_data    = i_src_byte;
                                n_res.write_is_xor  = !r_write_mode;
                                n_column            = pix_column;
                                n_dest              = pix_dest;
                                n_run_left          = run_dec;
                                if (run_dec == '0) begin
                                    n_phase = PH_CMD;
                                end
                            end
                            PH_LONG_LO: begin
                                n_long_low = i_src_byte;
                                n_phase    = PH_LONG_HI;
                            end
                            PH_LONG_HI: begin
                                if (long_val == f40_pkg::LONG_END) begin
                                    n_phase = PH_DONE;
                                end else if (!long_val[f40_pkg::LONG_RUN_BIT]) begin
                                    skip_go  = 1'b1;
                                    skip_len = long_val[f40_pkg::RUN_W-1:0];
                                    n_phase  = PH_CMD;
                                end else begin
                                    n_run_left = {1'b0, long_val[13:0]};
                                    if (long_val[f40_pkg::LONG_FILL_BIT]) begin
                                        n_phase = PH_FILL_VALUE;
                                    end else begin
                                        // an empty literal goes straight back to commands
                                        n_phase = (long_val[13:0] == '0) ? PH_CMD : PH_LITERAL;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    n_res.next_wanted = (n_phase == PH_DONE)     ? f40_pkg::WANT_DONE :
                                        (n_phase == PH_FILL_RUN) ? f40_pkg::WANT_ADVANCE
                                                                 : f40_pkg::WANT_BYTE;
                    n_skip_n = skip_len;
                    n_seq    = skip_go ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                // hold until the divider has the row count and new column
                if (div_done) begin
                    n_column = div_rem;
                    n_seq    = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod = prod_full[ADDR_BITS-1:0];
                n_seq  = ST_ADD;
            end
            ST_ADD: begin
                n_dest = r_dest + ADDR_BITS'(r_skip_n) + r_prod;
                n_seq  = ST_DONE;
            end
            ST_DONE: begin
                // advance the result into the output register once it is free
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_seq       = ST_IDLE;
                end
            end
            default: n_seq = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= ST_IDLE;
            r_phase      <= PH_CMD;
            r_run_left   <= '0;
            r_fill_value <= '0;
            r_long_low   <= '0;
            r_column     <= '0;
            r_dest       <= '0;
            r_skip_n     <= '0;
            r_prod       <= '0;
            r_rect_width <= 12'd320;
            r_row_pitch  <= 12'd320;
            r_write_mode <= 1'b0;
            r_res        <= '0;
            r_out        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_seq        <= n_seq;
            r_phase      <= n_phase;
            r_run_left   <= n_run_left;
            r_fill_value <= n_fill_value;
            r_long_low   <= n_long_low;
            r_column     <= n_column;
            r_dest       <= n_dest;
            r_skip_n     <= n_skip_n;
            r_prod       <= n_prod;
            r_rect_width <= n_rect_width;
            r_row_pitch  <= n_row_pitch;
            r_write_mode <= n_write_mode;
            r_res        <= n_res;
            r_out        <= n_out;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_valid   = r_out.write_valid;
    assign o_write_address = r_out.write_address;
    assign o_write_data    = r_out.write_data;
    assign o_write_is_xor  = r_out.write_is_xor;
    assign o_next_wanted   = r_out.next_wanted;
    assign o_kind_error    = r_out.kind_error;

endmodule

// File: rtl/f40_chk.sv
// Port-level checks for the format40 decoder, bound to the top level.
module f40_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_write_valid,
    input logic [19:0] o_write_address,
    input logic [7:0]  o_write_data,
    input logic        o_write_is_xor,
    input logic [1:0]  o_next_wanted,
    input logic        o_kind_error
);

    // a stalled result stays valid and keeps its address, data, next-request code and error flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_write_address)
            && $stable(o_write_data) && $stable(o_next_wanted) && $stable(o_kind_error))
        else $error("result changed while stalled");

    // one request at a time: an accepted request closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a request was taken");

    // a wrongly typed request never writes
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind_error |-> !o_write_valid)
        else $error("write alongside a kind error");

    // a result without a write carries zero payload
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_valid |->
            o_write_address == 20'd0 && o_write_data == 8'd0 && !o_write_is_xor)
        else $error("payload set on a result with no write");

    // the next-request code is always one of the three defined kinds
    a_want_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_next_wanted != 2'd3)
        else $error("unknown next request code");

endmodule

bind format40_rect_delta_decoder f40_chk u_f40_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_write_valid   (o_write_valid),
    .o_write_address (o_write_address),
    .o_write_data    (o_write_data),
    .o_write_is_xor  (o_write_is_xor),
    .o_next_wanted   (o_next_wanted),
    .o_kind_error    (o_kind_error)
);
